### hdl/utf16_to_utf8_encoder_defines.svh
// Assertion macros for the UTF-16 to UTF-8 encoder.
// Included by the top level; needs no other file.
`ifndef UTF16_TO_UTF8_ENCODER_DEFINES_SVH
`define UTF16_TO_UTF8_ENCODER_DEFINES_SVH
`ifndef ASSERT_OFF
`define U16U8_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define U16U8_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define U16U8_ASSERT(lbl, clk, rst, prop, msg)
`define U16U8_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### hdl/u16u8_pkg.sv
// Shared types, constants and the UTF-8 byte encoder function.
// Used by every module of the UTF-16 to UTF-8 encoder; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package u16u8_pkg;

   localparam int UNIT_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int CP_W        = 21;
   localparam int HELD_W      = 10;
   localparam int MAX_BYTES   = 6;
   localparam int CNT_W       = 3;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [UNIT_W-1:0] SURR_HIGH_MIN = 16'hD800;
   localparam logic [UNIT_W-1:0] SURR_HIGH_MAX = 16'hDBFF;
   localparam logic [UNIT_W-1:0] SURR_LOW_MIN  = 16'hDC00;
   localparam logic [UNIT_W-1:0] SURR_LOW_MAX  = 16'hDFFF;
   localparam logic [5:0]        SURR_HIGH_TAG = 6'b110110;

   localparam logic [CP_W-1:0] CP_SUPP_BASE = 21'h10000;
   localparam logic [CP_W-1:0] CP_TWO_MIN   = 21'h80;
   localparam logic [CP_W-1:0] CP_THREE_MIN = 21'h800;

   localparam logic [BYTE_W-1:0] LEAD_TWO   = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD_THREE = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD_FOUR  = 8'hF0;
   localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;

   typedef struct packed {
      logic [UNIT_W-1:0] code_unit;
      logic              string_end;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_last;
      logic              string_done;
   } rsp_type;

   // One queued job: the bytes that one request produces, first byte at index 0.
   typedef struct packed {
      logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [CNT_W-1:0]                 count;
      logic                             last;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      logic [3:0][BYTE_W-1:0] bytes;
      logic [CNT_W-1:0]       len;
   } enc_type;

   // Continuation byte from six payload bits.
   function automatic logic [BYTE_W-1:0] cont_byte(input logic [5:0] bits);
      return CONT_TAG | ({2'b00, bits} & CONT_MASK);
   endfunction

   // Encodes one code point into one to four UTF-8 bytes.
   function automatic enc_type utf8_encode(input logic [CP_W-1:0] cp);
      enc_type e;
      e = '0;
      if (cp < CP_TWO_MIN) begin
         e.len      = 3'd1;
         e.bytes[0] = cp[7:0];
      end else if (cp < CP_THREE_MIN) begin
         e.len      = 3'd2;
         e.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
         e.bytes[1] = cont_byte(cp[5:0]);
      end else if (cp < CP_SUPP_BASE) begin
         e.len      = 3'd3;
         e.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
         e.bytes[1] = cont_byte(cp[11:6]);
         e.bytes[2] = cont_byte(cp[5:0]);
      end else begin
         e.len      = 3'd4;
         e.bytes[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
         e.bytes[1] = cont_byte(cp[17:12]);
         e.bytes[2] = cont_byte(cp[11:6]);
         e.bytes[3] = cont_byte(cp[5:0]);
      end
      return e;
   endfunction

endpackage
`default_nettype wire

### hdl/utf16_to_utf8_encoder.sv
// Top level of the UTF-16 to UTF-8 encoder: front stage, job queue, back stage.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back and the defines header.
//
//   channel  direction  payload                          handshake
//   req      in         code_unit[15:0], string_end      req_valid / req_stall
//   rsp      out        out_byte[7:0], run_last, done    rsp_valid / rsp_stall
//
// A request is taken whenever the job queue has room; it makes zero to six bytes.
// The back stage sends one byte per cycle while the response is not stalled.
// Reset is synchronous and empties the queue and the held surrogate.
// A stalled response holds; the front keeps taking requests until the queue fills.
`timescale 1ns / 1ps
`default_nettype none
`include "utf16_to_utf8_encoder_defines.svh"
module utf16_to_utf8_encoder #(
   parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  u16u8_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output u16u8_pkg::rsp_type  rsp_payload
);

   u16u8_pkg::job_type    push_job, head_job;
   u16u8_pkg::q_stat_type q_stat;
   logic                  push, pop;

   // Classify requests and build byte jobs.
   u16u8_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_stat      (q_stat),
      .push        (push),
      .job         (push_job)
   );

   // Decouple the two stages.
   u16u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_stat   (q_stat)
   );

   // Serialize jobs into response bytes.
   u16u8_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .q_stat      (q_stat),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Queue must never be written when full or read when empty.
   `U16U8_ASSERT_IMPLIES(a_push_not_full, clock, reset, push, !q_stat.full, "push while full")
   `U16U8_ASSERT_IMPLIES(a_pop_not_empty, clock, reset, pop, !q_stat.empty, "pop while empty")
   // The end of a string is always the end of a request's bytes.
   `U16U8_ASSERT_IMPLIES(a_done_is_last, clock, reset, rsp_valid && rsp_payload.string_done,
      rsp_payload.run_last, "string_done without run_last")

endmodule
`default_nettype wire

### hdl/u16u8_front.sv
// Front stage: accepts code units, pairs surrogates and builds byte jobs.
// Depends on u16u8_pkg.
`timescale 1ns / 1ps
`default_nettype none
module u16u8_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  u16u8_pkg::req_type   req_payload,
   input  u16u8_pkg::q_stat_type q_stat,
   output logic                 push,
   output u16u8_pkg::job_type   job
);

   logic                            held_valid_ff, held_valid_in;
   logic [u16u8_pkg::HELD_W-1:0]    held_bits_ff, held_bits_in;
   logic                            accept;
   logic                            is_high, is_low, hold_now;
   logic [u16u8_pkg::UNIT_W-1:0]    unit;
   u16u8_pkg::enc_type              enc_pair, enc_held, enc_unit;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !q_stat.full;
   assign unit      = req_payload.code_unit;

   // Classify the unit.
   always_comb begin
      is_high  = unit inside {[u16u8_pkg::SURR_HIGH_MIN:u16u8_pkg::SURR_HIGH_MAX]};
      is_low   = unit inside {[u16u8_pkg::SURR_LOW_MIN:u16u8_pkg::SURR_LOW_MAX]};
      hold_now = is_high && !req_payload.string_end;
   end

   // Encode the surrogate pair, the held unit alone and the current unit alone.
   always_comb begin
      enc_pair = u16u8_pkg::utf8_encode(u16u8_pkg::CP_SUPP_BASE
                 + {1'b0, held_bits_ff, unit[9:0]});
      enc_held = u16u8_pkg::utf8_encode({5'd0, u16u8_pkg::SURR_HIGH_TAG, held_bits_ff});
      enc_unit = u16u8_pkg::utf8_encode({5'd0, unit});
   end

   // Assemble the job; a flushed high surrogate always takes the first three bytes.
   always_comb begin
      job      = '0;
      job.last = req_payload.string_end;
      if (held_valid_ff && is_low) begin
         job.bytes[3:0] = enc_pair.bytes;
         job.count      = enc_pair.len;
      end else if (held_valid_ff) begin
         job.bytes[2:0] = enc_held.bytes[2:0];
         job.count      = 3'd3;
         if (!hold_now) begin
            job.bytes[5:3] = enc_unit.bytes[2:0];
            job.count      = 3'd3 + enc_unit.len;
         end
      end else if (!hold_now) begin
         job.bytes[2:0] = enc_unit.bytes[2:0];
         job.count      = enc_unit.len;
      end
   end

   // A unit that is only held makes no job.
   assign push = accept && (job.count != '0);

   // Held surrogate state.
   always_comb begin
      held_valid_in = held_valid_ff;
      held_bits_in  = held_bits_ff;
      if (accept) begin
         if (held_valid_ff && is_low) begin
            held_valid_in = 1'b0;
            held_bits_in  = '0;
         end else begin
            held_valid_in = hold_now;
            held_bits_in  = hold_now ? unit[9:0] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_bits_ff  <= '0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_bits_ff  <= held_bits_in;
      end
   end

endmodule
`default_nettype wire

### hdl/u16u8_queue.sv
// Short job queue between the front and back stages.
// Depends on u16u8_pkg.
`timescale 1ns / 1ps
`default_nettype none
module u16u8_queue #(
   parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  u16u8_pkg::job_type    push_job,
   input  wire                   pop,
   output u16u8_pkg::job_type    head_job,
   output u16u8_pkg::q_stat_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   u16u8_pkg::job_type entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head_job     = entries_ff[rd_ptr_ff];

   // Pointer and occupancy update; pointers wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage holds no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

### hdl/u16u8_back.sv
// Back stage: walks each job one byte per unstalled cycle into the response register.
// Depends on u16u8_pkg.
`timescale 1ns / 1ps
`default_nettype none
module u16u8_back (
   input  wire                   clock,
   input  wire                   reset,
   input  u16u8_pkg::job_type    head_job,
   input  u16u8_pkg::q_stat_type q_stat,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output u16u8_pkg::rsp_type    rsp_payload
);

   u16u8_pkg::job_type            job_ff, job_in;
   logic                          job_valid_ff, job_valid_in;
   logic [u16u8_pkg::CNT_W-1:0]   idx_ff, idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   u16u8_pkg::rsp_type            rsp_ff, rsp_in;
   logic                          advance, take, finishing;

   // The response register moves when empty or taken.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign take      = job_valid_ff && advance;
   assign finishing = take && (idx_ff == job_ff.count - 1'b1);
   assign pop       = !q_stat.empty && (!job_valid_ff || finishing);

   // Job sequencer.
   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      idx_in       = idx_ff;
      if (pop) begin
         job_in       = head_job;
         job_valid_in = 1'b1;
         idx_in       = '0;
      end else if (finishing) begin
         job_valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // Next response byte and its flags.
   always_comb begin
      rsp_valid_in = advance ? job_valid_ff : rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (take) begin
         rsp_in.out_byte    = job_ff.bytes[idx_ff];
         rsp_in.run_last    = finishing;
         rsp_in.string_done = finishing && job_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

### test/tb_utf16_to_utf8_encoder.sv
// Self-checking testbench for the UTF-16 to UTF-8 encoder: directed units, then random strings.
// It predicts the bytes of every accepted request and checks each response against them.
// Depends on u16u8_pkg and the utf16_to_utf8_encoder top level.
`timescale 1ns / 1ps
module tb_utf16_to_utf8_encoder;

   localparam int QUIET_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 32;
   localparam int RANDOM_UNITS  = 60;
   localparam int DIRECTED_ROWS = 24;
   localparam int MAX_REPORTS   = 10;

   // One directed request; the bytes are typed in only where typed_in is set.
   typedef struct packed {
      logic [15:0]      unit;
      logic             fin;
      logic             typed_in;
      logic [2:0]       count;
      logic [0:5][7:0]  bytes;
   } dir_row_type;

   // Flavors of random code units.
   typedef enum int {
      KIND_ONE_BYTE,
      KIND_TWO_BYTE,
      KIND_THREE_BYTE,
      KIND_HIGH_SURR,
      KIND_LOW_SURR,
      KIND_NOISE
   } unit_kind_type;

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   u16u8_pkg::req_type req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   u16u8_pkg::rsp_type rsp_payload;

   // Predictor state: the held high surrogate.
   logic       held_ok   = 1'b0;
   logic [9:0] held_bits = '0;

   logic [7:0]         utf8_seq[$];
   logic [7:0]         row_bytes[$];
   logic               row_typed = 1'b0;
   u16u8_pkg::rsp_type pending_bytes[$];
   int                 mismatch_count = 0;
   int                 quiet_cycles   = 0;
   int                 send_idle_pct  = 36;
   int                 recv_idle_pct  = 82;
   dir_row_type        dir_rows [0:DIRECTED_ROWS-1];

   utf16_to_utf8_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Appends one byte to the predicted byte sequence.
   function automatic void add_byte(input logic [7:0] b);
      utf8_seq.insert(utf8_seq.size(), b);
   endfunction

   // Appends the UTF-8 form of one code point to the byte sequence.
   function automatic void add_code_point(input logic [20:0] cp);
      if (cp < 21'h80) begin
         add_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
         add_byte(8'hC0 | {3'b000, cp[10:6]});
         add_byte(8'h80 | {2'b00, cp[5:0]});
      end else if (cp < 21'h10000) begin
         add_byte(8'hE0 | {4'b0000, cp[15:12]});
         add_byte(8'h80 | {2'b00, cp[11:6]});
         add_byte(8'h80 | {2'b00, cp[5:0]});
      end else begin
         add_byte(8'hF0 | {5'b00000, cp[20:18]});
         add_byte(8'h80 | {2'b00, cp[17:12]});
         add_byte(8'h80 | {2'b00, cp[11:6]});
         add_byte(8'h80 | {2'b00, cp[5:0]});
      end
   endfunction

   // Works out the bytes of one request and advances the held surrogate.
   function automatic void encode_unit(input u16u8_pkg::req_type r);
      logic is_high;
      logic is_low;
      is_high = (r.code_unit >= u16u8_pkg::SURR_HIGH_MIN)
                && (r.code_unit <= u16u8_pkg::SURR_HIGH_MAX);
      is_low  = (r.code_unit >= u16u8_pkg::SURR_LOW_MIN)
                && (r.code_unit <= u16u8_pkg::SURR_LOW_MAX);
      utf8_seq.delete();
      if (held_ok && is_low) begin
         // A complete pair becomes one supplementary code point.
         add_code_point(21'h10000 + {1'b0, held_bits, r.code_unit[9:0]});
         held_ok   = 1'b0;
         held_bits = '0;
      end else begin
         // An unpaired held unit goes out on its own first.
         if (held_ok) begin
            add_code_point({5'b00000, u16u8_pkg::SURR_HIGH_TAG, held_bits});
            held_ok   = 1'b0;
            held_bits = '0;
         end
         if (is_high && !r.string_end) begin
            held_ok   = 1'b1;
            held_bits = r.code_unit[9:0];
         end else begin
            add_code_point({5'b00000, r.code_unit});
         end
      end
   endfunction

   // Turns the byte sequence into expected responses with their flags.
   function automatic void queue_expected(input logic fin);
      u16u8_pkg::rsp_type e;
      for (int k = 0; k < utf8_seq.size(); k++) begin
         e.out_byte    = utf8_seq[k];
         e.run_last    = (k == utf8_seq.size() - 1);
         e.string_done = e.run_last && fin;
         pending_bytes.insert(pending_bytes.size(), e);
      end
   endfunction

   function automatic void flag_mismatch(input string what, input u16u8_pkg::rsp_type e,
                                         input u16u8_pkg::rsp_type g);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%t: %s: expected byte %h last %b done %b, got byte %h last %b done %b",
                  $realtime, what, e.out_byte, e.run_last, e.string_done,
                  g.out_byte, g.run_last, g.string_done);
      end
   endfunction

   // Prediction on accepted requests, then checking of accepted responses.
   always @(posedge clock) begin
      u16u8_pkg::rsp_type e;
      if (!reset && req_valid && !req_stall) begin
         encode_unit(req_payload);
         if (row_typed) begin
            utf8_seq = row_bytes;
         end
         queue_expected(req_payload.string_end);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bytes.size() == 0) begin
            flag_mismatch("response with nothing pending", '0, rsp_payload);
         end else begin
            e = pending_bytes.pop_front();
            if (rsp_payload.out_byte !== e.out_byte || rsp_payload.run_last !== e.run_last
                || rsp_payload.string_done !== e.string_done) begin
               flag_mismatch("mismatch", e, rsp_payload);
            end
         end
      end
   end

   // Watchdog: ends the run after too long without any handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** utf16_to_utf8_encoder: FAILED **");
         $finish;
      end
   end

   // Receiver stalls at random, redrawn at every falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Sends one request; entered and left at a falling edge with valid still high.
   task automatic send_unit(input logic [15:0] unit, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid              <= 1'b1;
      req_payload.code_unit  <= unit;
      req_payload.string_end <= fin;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Draws one code unit of a given flavor.
   function automatic logic [15:0] pick_unit(input unit_kind_type kind);
      case (kind)
         KIND_ONE_BYTE:   pick_unit = 16'($urandom_range(16'h007F));
         KIND_TWO_BYTE:   pick_unit = 16'($urandom_range(16'h07FF, 16'h0080));
         KIND_THREE_BYTE: pick_unit = ($urandom_range(1) != 0)
                                      ? 16'($urandom_range(16'hD7FF, 16'h0800))
                                      : 16'($urandom_range(16'hFFFF, 16'hE000));
         KIND_HIGH_SURR:  pick_unit = 16'($urandom_range(u16u8_pkg::SURR_HIGH_MAX,
                                                          u16u8_pkg::SURR_HIGH_MIN));
         KIND_LOW_SURR:   pick_unit = 16'($urandom_range(u16u8_pkg::SURR_LOW_MAX,
                                                          u16u8_pkg::SURR_LOW_MIN));
         default:         pick_unit = 16'($urandom);
      endcase
   endfunction

   // Random strings, mostly well-formed text with pairs, some broken sequences and noise.
   task automatic send_random_strings(input int unit_goal);
      int          sent;
      int          len;
      int          kind;
      logic [15:0] units[$];
      sent = 0;
      while (sent < unit_goal) begin
         units.delete();
         len = $urandom_range(8, 1);
         while (units.size() < len) begin
            kind = $urandom_range(9);
            if (kind <= 2) begin
               units.insert(units.size(), pick_unit(KIND_ONE_BYTE));
            end else if (kind == 3) begin
               units.insert(units.size(), pick_unit(KIND_TWO_BYTE));
            end else if (kind <= 5) begin
               units.insert(units.size(), pick_unit(KIND_THREE_BYTE));
            end else if (kind <= 7) begin
               units.insert(units.size(), pick_unit(KIND_HIGH_SURR));
               units.insert(units.size(), pick_unit(KIND_LOW_SURR));
            end else if (kind == 8) begin
               units.insert(units.size(), pick_unit(($urandom_range(1) != 0)
                                                    ? KIND_HIGH_SURR : KIND_LOW_SURR));
            end else begin
               units.insert(units.size(), pick_unit(KIND_NOISE));
            end
         end
         foreach (units[i]) begin
            send_unit(units[i], i == units.size() - 1);
         end
         sent += units.size();
      end
   endtask

   // Holds the request side low until every predicted byte has come back.
   task automatic drain_pending();
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) begin
         @(negedge clock);
      end
      @(negedge clock);
   endtask

   // Main sequence: reset, directed table, three random phases, drain.
   initial begin
      dir_rows = '{
         // Range edges of the one-, two- and three-byte forms.
         '{16'h0000, 1'b0, 1'b1, 3'd1, 48'h00_00_00_00_00_00},
         '{16'h007F, 1'b0, 1'b1, 3'd1, 48'h7F_00_00_00_00_00},
         '{16'h0080, 1'b0, 1'b1, 3'd2, 48'hC2_80_00_00_00_00},
         '{16'h07FF, 1'b0, 1'b1, 3'd2, 48'hDF_BF_00_00_00_00},
         '{16'h0800, 1'b0, 1'b1, 3'd3, 48'hE0_A0_80_00_00_00},
         '{16'hFFFF, 1'b1, 1'b1, 3'd3, 48'hEF_BF_BF_00_00_00},
         // Lowest and highest surrogate pairs; the high half makes no bytes.
         '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00},
         '{16'hDC00, 1'b0, 1'b1, 3'd4, 48'hF0_90_80_80_00_00},
         '{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00},
         '{16'hDFFF, 1'b1, 1'b1, 3'd4, 48'hF4_8F_BF_BF_00_00},
         // Held high surrogate broken by an ordinary unit.
         '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00},
         '{16'h0041, 1'b0, 1'b1, 3'd4, 48'hED_A0_80_41_00_00},
         // Held high surrogate broken by another high one, then by a wide unit.
         '{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00},
         '{16'hD800, 1'b0, 1'b1, 3'd3, 48'hED_AF_BF_00_00_00},
         '{16'hFFFF, 1'b0, 1'b1, 3'd6, 48'hED_A0_80_EF_BF_BF},
         // Lone low surrogates.
         '{16'hDC00, 1'b0, 1'b1, 3'd3, 48'hED_B0_80_00_00_00},
         '{16'hDFFF, 1'b1, 1'b1, 3'd3, 48'hED_BF_BF_00_00_00},
         // High surrogate on the last unit is flushed at once.
         '{16'hDBFF, 1'b1, 1'b1, 3'd3, 48'hED_AF_BF_00_00_00},
         '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00},
         '{16'hDBFF, 1'b1, 1'b1, 3'd6, 48'hED_A0_80_ED_AF_BF},
         // One-unit string, then a mixed string left to the predictor.
         '{16'h0041, 1'b1, 1'b1, 3'd1, 48'h41_00_00_00_00_00},
         '{16'h1234, 1'b0, 1'b0, 3'd0, 48'h00_00_00_00_00_00},
         '{16'hD834, 1'b0, 1'b0, 3'd0, 48'h00_00_00_00_00_00},
         '{16'hDD1E, 1'b1, 1'b0, 3'd0, 48'h00_00_00_00_00_00}
      };
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Phase one: directed rows, then random strings with a slow receiver.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row_typed = dir_rows[i].typed_in;
         row_bytes.delete();
         for (int k = 0; k < dir_rows[i].count; k++) begin
            row_bytes.insert(row_bytes.size(), dir_rows[i].bytes[k]);
         end
         send_unit(dir_rows[i].unit, dir_rows[i].fin);
      end
      row_typed = 1'b0;
      send_random_strings(RANDOM_UNITS);
      drain_pending();

      // Phase two: slow sender, fast receiver.
      send_idle_pct = 82;
      recv_idle_pct = 36;
      send_random_strings(RANDOM_UNITS);
      drain_pending();

      // Phase three: no idling on either side.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_strings(RANDOM_UNITS);
      req_valid <= 1'b0;

      while (pending_bytes.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("** utf16_to_utf8_encoder: PASSED **");
      end else begin
         $display("** utf16_to_utf8_encoder: FAILED **");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/u16u8_pkg.sv
hdl/u16u8_front.sv
hdl/u16u8_queue.sv
hdl/u16u8_back.sv
hdl/utf16_to_utf8_encoder.sv
test/tb_utf16_to_utf8_encoder.sv
